[design/mhe_pkg.sv]
package mhe_pkg;

	typedef struct packed {
		logic [15:0] theta;
		logic [15:0] phi;
		logic [5:0]  orbital;
	} item_t;

	typedef struct packed {
		logic signed [31:0] real_part;
		logic signed [31:0] imag_part;
		logic               range_error;
	} result_t;

	localparam logic [52:0] INV4PI_Q56 = 53'd5734161139222660;
	localparam logic [33:0] CORDIC_K   = 34'd652032874;
	localparam logic [30:0] Q30_ONE    = 31'd1073741824;
	localparam int          CORDIC_STEPS = 30;

	// arctangent of 2^-i in turns * 2^32
	localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
		30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
		30'd20, 30'd10, 30'd5, 30'd3, 30'd1
	};

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[design/monopole_harmonic_evaluator.sv]
// per word: two 30-step cordic passes, and one multiply plus renormalize shifts per power factor,
// with L = lz_max power factors in all
// first word after reset or an lz_max write also fills the prefactor table (L+1 entries)
// with the serial divider and the serial square root; one word at a time
// results come on done for one cycle and cannot be stalled
// reset clears control state and lz_max; table contents stay undefined until filled
module monopole_harmonic_evaluator #(
	parameter int MAX_LZ     = 63,
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  mhe_pkg::item_t        item,
	output logic                  done,
	output mhe_pkg::result_t      result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import mhe_pkg::*;

	localparam int DEPTH = MAX_LZ + 1;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_GSQ    = 5'd1;
	localparam logic [4:0] S_GWAIT  = 5'd2;
	localparam logic [4:0] S_FNORM  = 5'd3;
	localparam logic [4:0] S_FSQ    = 5'd4;
	localparam logic [4:0] S_FSWAIT = 5'd5;
	localparam logic [4:0] S_FWR    = 5'd6;
	localparam logic [4:0] S_FMUL   = 5'd7;
	localparam logic [4:0] S_FDIV   = 5'd8;
	localparam logic [4:0] S_CHECK  = 5'd9;
	localparam logic [4:0] S_TCORD  = 5'd10;
	localparam logic [4:0] S_PNORM  = 5'd11;
	localparam logic [4:0] S_PLOOP  = 5'd12;
	localparam logic [4:0] S_PMUL   = 5'd13;
	localparam logic [4:0] S_PMAG   = 5'd14;
	localparam logic [4:0] S_PHCORD = 5'd15;
	localparam logic [4:0] S_OUT1   = 5'd16;
	localparam logic [4:0] S_OUT2   = 5'd17;

	logic [4:0]  state_q;
	logic [5:0]  lz_max_q;
	logic        valid_q;
	logic [ANGLE_BITS-1:0] th_q, ph_q;
	logic [5:0]  k_q, kf_q, cnt_c_q, cnt_s_q;
	logic [63:0] b_q, n_q;
	logic [4:0]  u_q;
	logic [29:0] g_q;
	logic [61:0] rg_q;
	logic [30:0] cth_q, sth_q, mag_q;
	logic [33:0] m_q;
	logic signed [15:0] e_q;
	logic [61:0] prod_q;
	logic [31:0] phase_q;
	logic signed [65:0] mprod_q;
	logic signed [31:0] re_q;
	logic [39:0] rd_q;
	logic        done_q;
	result_t     res_q;

	logic [39:0] table_mem [DEPTH];

	// arithmetic units: cordic and square root are shared, the divider serves only the table fill
	logic               cor_go, cor_done;
	logic [31:0]        cor_angle;
	logic signed [33:0] cor_c, cor_s;
	logic               sq_go, sq_done;
	logic [63:0]        sq_rad;
	logic [31:0]        sq_root;
	logic               dv_go, dv_done;
	logic [65:0]        dv_dividend, dv_q;
	logic [5:0]         dv_divisor;

	logic        lz_over, k_over;
	logic [63:0] g_rad;
	logic [70:0] bmul;
	logic [6:0]  bfac;
	logic [31:0] th_turn, ph32, dext, phase_raw;
	logic [7:0]  dk;
	logic [30:0] f_sel;
	logic signed [15:0] sh, nsh;
	logic [30:0] mag_c;
	logic [30:0] cth_c, sth_c;
	logic        wr_en, rd_en;
	logic [IW-1:0] waddr, raddr;
	logic        cfg_wr;

	assign lz_over = 32'(lz_max_q) > MAX_LZ;
	assign k_over  = k_q > lz_max_q;
	assign g_rad   = 64'({1'b0, lz_max_q} + 7'd1) * 64'(INV4PI_Q56);
	assign bfac    = {1'b0, lz_max_q} + 7'd1 - {1'b0, kf_q};
	assign bmul    = 71'(b_q) * 71'(bfac);
	assign th_turn = 32'(th_q) << (30 - ANGLE_BITS);
	assign ph32    = 32'(ph_q);
	assign dk      = {1'b0, k_q, 1'b0} - {2'b00, lz_max_q};
	assign dext    = {{24{dk[7]}}, dk};
	assign phase_raw = 32'(ph32 * dext) << (31 - ANGLE_BITS);
	assign f_sel   = (cnt_c_q != 6'd0) ? cth_q : sth_q;

	function automatic logic [30:0] clamp_q30(input logic signed [33:0] v);
		logic [30:0] r;
		if (v[33]) begin
			r = '0;
		end else if (v > signed'({3'b000, Q30_ONE})) begin
			r = Q30_ONE;
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

	assign cth_c = clamp_q30(cor_c);
	assign sth_c = clamp_q30(cor_s);

	// Q28 magnitude from mantissa and exponent
	assign sh  = e_q + 16'sd28;
	assign nsh = -sh;
	always_comb begin
		if (m_q == 34'd0) begin
			mag_c = '0;
		end else if (sh > 16'sd0) begin
			mag_c = 31'h7FFFFFFF;
		end else if (nsh >= 16'sd31) begin
			mag_c = '0;
		end else begin
			mag_c = m_q[30:0] >> nsh[4:0];
		end
	end

	assign cor_go    = ((state_q == S_CHECK) && !lz_over && !k_over) || (state_q == S_PMAG);
	assign cor_angle = (state_q == S_PMAG) ? phase_q : th_turn;
	assign sq_go     = ((state_q == S_GSQ) && !lz_over) || (state_q == S_FSQ);
	assign sq_rad    = (state_q == S_FSQ) ? n_q : g_rad;
	assign dv_go     = (state_q == S_FMUL);
	assign dv_dividend = bmul[65:0];
	assign dv_divisor  = kf_q;

	assign wr_en = (state_q == S_FWR);
	assign waddr = IW'(kf_q);
	assign rd_en = cor_go && (state_q == S_CHECK);
	assign raddr = IW'(k_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[waddr] <= {1'b0, u_q, 34'(rg_q[61:29])};
		end
		if (rd_en) begin
			rd_q <= table_mem[raddr];
		end
	end

	mhe_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (cor_go),
		.angle   (cor_angle),
		.done    (cor_done),
		.cos_val (cor_c),
		.sin_val (cor_s)
	);

	mhe_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sq_go),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (sq_root)
	);

	mhe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (dv_go),
		.dividend (dv_dividend),
		.divisor  (dv_divisor),
		.done     (dv_done),
		.quotient (dv_q)
	);

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {26'd0, lz_max_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			lz_max_q <= '0;
			valid_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr && !paddr[2]) begin
				lz_max_q <= pwdata[5:0];
				valid_q  <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= valid_q ? S_CHECK : S_GSQ;
					end
				end
				S_GSQ: begin
					valid_q <= 1'b1;
					state_q <= lz_over ? S_CHECK : S_GWAIT;
				end
				S_GWAIT: begin
					if (sq_done) begin
						state_q <= S_FNORM;
					end
				end
				S_FNORM: begin
					if (n_q[63:62] != 2'b00) begin
						state_q <= S_FSQ;
					end
				end
				S_FSQ: state_q <= S_FSWAIT;
				S_FSWAIT: begin
					if (sq_done) begin
						state_q <= S_FWR;
					end
				end
				S_FWR: state_q <= (kf_q == lz_max_q) ? S_CHECK : S_FMUL;
				S_FMUL: state_q <= S_FDIV;
				S_FDIV: begin
					if (dv_done) begin
						state_q <= S_FNORM;
					end
				end
				S_CHECK: begin
					if (lz_over || k_over) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_TCORD;
					end
				end
				S_TCORD: begin
					if (cor_done) begin
						state_q <= S_PNORM;
					end
				end
				S_PNORM: begin
					if (m_q == 34'd0 || (m_q[33:31] == 3'd0 && m_q[30])) begin
						state_q <= S_PLOOP;
					end
				end
				S_PLOOP: begin
					if (m_q == 34'd0 || (cnt_c_q == 6'd0 && cnt_s_q == 6'd0)) begin
						state_q <= S_PMAG;
					end else begin
						state_q <= S_PMUL;
					end
				end
				S_PMUL: state_q <= S_PNORM;
				S_PMAG: state_q <= S_PHCORD;
				S_PHCORD: begin
					if (cor_done) begin
						state_q <= S_OUT1;
					end
				end
				S_OUT1: state_q <= S_OUT2;
				S_OUT2: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				th_q <= ANGLE_BITS'(item.theta);
				ph_q <= ANGLE_BITS'(item.phi);
				k_q  <= item.orbital;
			end
			S_GWAIT: begin
				g_q  <= sq_root[29:0];
				b_q  <= 64'd1;
				n_q  <= 64'd1;
				u_q  <= '0;
				kf_q <= '0;
			end
			S_FNORM: begin
				if (n_q[63:62] == 2'b00) begin
					n_q <= {n_q[61:0], 2'b00};
					u_q <= u_q + 5'd1;
				end
			end
			S_FSWAIT: rg_q <= 62'(sq_root) * 62'(g_q);
			S_FWR: kf_q <= kf_q + 6'd1;
			S_FDIV: begin
				b_q <= dv_q[63:0];
				n_q <= dv_q[63:0];
				u_q <= '0;
			end
			S_CHECK: begin
				phase_q <= phase_raw;
				cnt_c_q <= k_q;
				cnt_s_q <= lz_max_q - k_q;
				res_q   <= '{real_part: '0, imag_part: '0, range_error: 1'b1};
			end
			S_TCORD: begin
				cth_q <= cth_c;
				sth_q <= sth_c;
				m_q   <= rd_q[33:0];
				e_q   <= 16'sd1 - signed'(16'(rd_q[39:34]));
			end
			S_PNORM: begin
				if (m_q != 34'd0) begin
					if (m_q[33:31] != 3'd0) begin
						m_q <= {1'b0, m_q[33:1]};
						e_q <= e_q + 16'sd1;
					end else if (!m_q[30]) begin
						m_q <= {m_q[32:0], 1'b0};
						e_q <= e_q - 16'sd1;
					end
				end
			end
			S_PLOOP: begin
				prod_q <= m_q[30:0] * f_sel;
				if (cnt_c_q != 6'd0) begin
					cnt_c_q <= cnt_c_q - 6'd1;
				end else if (cnt_s_q != 6'd0) begin
					cnt_s_q <= cnt_s_q - 6'd1;
				end
			end
			S_PMUL: m_q <= 34'(prod_q[61:30]);
			S_PMAG: mag_q <= mag_c;
			S_PHCORD: mprod_q <= signed'({35'd0, mag_q}) * 66'(cor_c);
			S_OUT1: begin
				re_q    <= sat32(mprod_q >>> 30);
				mprod_q <= signed'({35'd0, mag_q}) * 66'(cor_s);
			end
			S_OUT2: res_q <= '{real_part: re_q, imag_part: sat32(mprod_q >>> 30),
				range_error: 1'b0};
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while still working");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.range_error |-> result.real_part == 0 && result.imag_part == 0)
		else $error("rejected index with nonzero value");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not start work");

	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> valid_q) else $error("lookup with table not filled");

endmodule

[design/mhe_cordic.sv]
module mhe_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [31:0]         angle,
	output logic                done,
	output logic signed [33:0]  cos_val,
	output logic signed [33:0]  sin_val
);
	import mhe_pkg::*;

	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0]         step_q;
	logic               run_q, neg_q, done_q;
	logic               neg;
	logic [31:0]        a_fold, a_off;
	logic signed [33:0] xs, ys, at;

	assign a_off  = angle + 32'h40000000;
	assign neg    = a_off[31];
	assign a_fold = neg ? (angle ^ 32'h80000000) : angle;
	assign xs     = x_q >>> step_q;
	assign ys     = y_q >>> step_q;
	assign at     = signed'(34'(ATAN_TURNS[step_q]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == 5'(CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q   <= signed'(CORDIC_K);
			y_q   <= '0;
			z_q   <= signed'({{2{a_fold[31]}}, a_fold});
			neg_q <= neg;
		end else if (run_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign cos_val = neg_q ? -x_q : x_q;
	assign sin_val = neg_q ? -y_q : y_q;

endmodule

[design/mhe_isqrt.sv]
module mhe_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] n_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        run_q, done_q;
	logic [35:0] remt, trial;

	assign remt  = {rem_q, n_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			n_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			n_q <= {n_q[61:0], 2'b00};
			if (remt >= trial) begin
				rem_q  <= 34'(remt - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= 34'(remt);
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[design/mhe_div.sv]
module mhe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [65:0] dividend,
	input  logic [5:0]  divisor,
	output logic        done,
	output logic [65:0] quotient
);
	logic [65:0] dq_q;
	logic [5:0]  rem_q, dvs_q;
	logic [6:0]  cnt_q;
	logic        run_q, done_q;
	logic [6:0]  remt;

	assign remt = {rem_q, dq_q[65]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == 7'd65) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	// dividend shifts out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (go) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (remt >= {1'b0, dvs_q}) begin
				rem_q <= 6'(remt - {1'b0, dvs_q});
				dq_q  <= {dq_q[64:0], 1'b1};
			end else begin
				rem_q <= remt[5:0];
				dq_q  <= {dq_q[64:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule
